/* design/cga_pkg.sv */
// Shared constants and types for the cooldown group allocator.
package cga_pkg;

  localparam int MAX_GROUPS = 1024;
  localparam int ADDR_W     = $clog2(MAX_GROUPS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int TIME_W     = 20;
  localparam int ID_W       = 10;
  localparam int GIU_W      = 11;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [ADDR_W-1:0] gid;
  } heap_entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    heap_entry_t       data;
  } heap_wr_t;

endpackage

/* design/cga_ifs.sv */
// Valid/ready channel interfaces for requests and results.
interface cga_req_if
  import cga_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] request_time;

  modport source (output valid, output request_time, input ready);
  modport sink (input valid, input request_time, output ready);
endinterface

interface cga_rsp_if
  import cga_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  group_id;
  logic             opened_new;
  logic             overflow;
  logic [GIU_W-1:0] groups_in_use;

  modport source (output valid, output group_id, output opened_new, output overflow,
                  output groups_in_use, input ready);
  modport sink (input valid, input group_id, input opened_new, input overflow,
                input groups_in_use, output ready);
endinterface

/* design/cga_heap_ram.sv */
// Heap storage: one write port, two registered read ports.
module cga_heap_ram
  import cga_pkg::*;
(
  input  logic              clk,
  input  heap_wr_t          wr,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output heap_entry_t       rd_data_a,
  output heap_entry_t       rd_data_b
);

  heap_entry_t mem [MAX_GROUPS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

/* design/cooldown_group_allocator.sv */
// Top level: request decision and heap sift sequencer around the heap RAM.
//
// in_req carries one request_time per transaction; out_rsp returns one result
// per request: group_id, opened_new, overflow and groups_in_use.
// Groups are kept in a binary min-heap keyed by {last-use time, group id} in a
// synchronous RAM. A request reads the root, then either inserts a new group
// and sifts it up, or restamps the root and sifts it down.
// An accepted request goes through the decision state, then, unless it is the
// first group or an overflow, a sift that moves one heap level per step, and
// then to the output register. One request is in flight at a time and
// in_req.ready returns the cycle after the result is loaded; each sift step is
// one RAM read/write round trip, which sets the rate.
// in_req.ready is high whenever no request is in flight, even while a result
// waits in the output register. If the receiver stalls, a finished result is
// held until the output register frees.
// Reset (rst_n low, synchronous) empties the group store; heap RAM contents
// are not cleared, since only entries below the group count are read.
module cooldown_group_allocator
  import cga_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  cga_req_if.sink    in_req,
  cga_rsp_if.source  out_rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_UP   = 3'd2;
  localparam logic [2:0] S_DN   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam int CW = ADDR_W + 2;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  heap_entry_t       key_r, key_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TIME_W-1:0] t_r, t_nxt;
  logic [ADDR_W-1:0] gid_r, gid_nxt;
  logic              opened_r, opened_nxt;
  logic              ovf_r, ovf_nxt;

  logic              out_valid_r;
  logic [ID_W-1:0]   out_gid_r;
  logic              out_opened_r;
  logic              out_ovf_r;
  logic [GIU_W-1:0]  out_giu_r;
  logic              out_load;

  heap_wr_t          wr;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  heap_entry_t       rd_a, rd_b;

  logic [TIME_W:0]   stamp_p1;
  logic              need_new;
  logic              full;
  logic [ADDR_W-1:0] ins_pos;
  logic [CW-1:0]     c1, c2;
  logic              c1_ok, c2_ok, use_b;
  heap_entry_t       child;
  logic [CW-1:0]     cidx;
  logic [CW-1:0]     n1, n2;

  cga_heap_ram u_ram (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign out_load     = (state_r == S_OUT) && (!out_valid_r || out_rsp.ready);

  assign stamp_p1 = {1'b0, rd_a.stamp} + {{TIME_W{1'b0}}, 1'b1};
  assign need_new = (count_r == '0) || (stamp_p1 >= {1'b0, t_r});
  assign full     = (count_r == CNT_W'(MAX_GROUPS));
  assign ins_pos  = count_r[ADDR_W-1:0];

  assign c1    = {pos_r, 1'b1} + CW'(0);
  assign c2    = CW'({pos_r, 1'b1}) + CW'(1);
  assign c1_ok = c1 < CW'(count_r);
  assign c2_ok = c2 < CW'(count_r);
  assign use_b = c2_ok && (rd_b < rd_a);
  assign child = use_b ? rd_b : rd_a;
  assign cidx  = use_b ? c2 : c1;
  assign n1    = CW'({cidx[ADDR_W-1:0], 1'b1});
  assign n2    = n1 + CW'(1);

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    count_nxt  = count_r;
    t_nxt      = t_r;
    gid_nxt    = gid_r;
    opened_nxt = opened_r;
    ovf_nxt    = ovf_r;
    wr         = '0;
    rd_addr_a  = '0;
    rd_addr_b  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          t_nxt     = in_req.request_time;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (need_new && full) begin
          gid_nxt    = '0;
          opened_nxt = 1'b0;
          ovf_nxt    = 1'b1;
          state_nxt  = S_OUT;
        end else if (need_new) begin
          gid_nxt    = ins_pos;
          opened_nxt = 1'b1;
          ovf_nxt    = 1'b0;
          count_nxt  = count_r + CNT_W'(1);
          key_nxt    = '{stamp: t_r, gid: ins_pos};
          pos_nxt    = ins_pos;
          if (ins_pos == '0) begin
            wr        = '{en: 1'b1, addr: '0, data: '{stamp: t_r, gid: ins_pos}};
            state_nxt = S_OUT;
          end else begin
            rd_addr_a = (ins_pos - ADDR_W'(1)) >> 1;
            state_nxt = S_UP;
          end
        end else begin
          gid_nxt    = rd_a.gid;
          opened_nxt = 1'b0;
          ovf_nxt    = 1'b0;
          key_nxt    = '{stamp: t_r, gid: rd_a.gid};
          pos_nxt    = '0;
          rd_addr_a  = ADDR_W'(1);
          rd_addr_b  = ADDR_W'(2);
          state_nxt  = S_DN;
        end
      end
      S_UP: begin
        if (rd_a > key_r) begin
          wr      = '{en: 1'b1, addr: pos_r, data: rd_a};
          pos_nxt = (pos_r - ADDR_W'(1)) >> 1;
          if (pos_nxt == '0) begin
            state_nxt = S_FIN;
          end else begin
            rd_addr_a = (pos_nxt - ADDR_W'(1)) >> 1;
          end
        end else begin
          wr        = '{en: 1'b1, addr: pos_r, data: key_r};
          state_nxt = S_OUT;
        end
      end
      S_DN: begin
        if (c1_ok && (child < key_r)) begin
          wr        = '{en: 1'b1, addr: pos_r, data: child};
          pos_nxt   = cidx[ADDR_W-1:0];
          rd_addr_a = n1[ADDR_W-1:0];
          rd_addr_b = n2[ADDR_W-1:0];
        end else begin
          wr        = '{en: 1'b1, addr: pos_r, data: key_r};
          state_nxt = S_OUT;
        end
      end
      S_FIN: begin
        wr        = '{en: 1'b1, addr: pos_r, data: key_r};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    t_r      <= t_nxt;
    gid_r    <= gid_nxt;
    opened_r <= opened_nxt;
    ovf_r    <= ovf_nxt;
    if (out_load) begin
      out_gid_r    <= ID_W'(gid_r);
      out_opened_r <= opened_r;
      out_ovf_r    <= ovf_r;
      out_giu_r    <= GIU_W'(count_r);
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.group_id      = out_gid_r;
  assign out_rsp.opened_new    = out_opened_r;
  assign out_rsp.overflow      = out_ovf_r;
  assign out_rsp.groups_in_use = out_giu_r;

endmodule

/* tb/sv/tb_cooldown_group_allocator.sv */
// Self-checking testbench for cooldown_group_allocator: directed, random, fill to overflow.
`timescale 1ns / 1ps

module tb_cooldown_group_allocator;
  import cga_pkg::*;

  localparam int TMAX      = (1 << TIME_W) - 1;
  localparam int N_DIR     = 14;
  localparam int N_MIXED   = 100;
  localparam int N_TAIL    = 30;
  localparam int SHOW_MAX  = 50;

  typedef struct packed {
    logic [ID_W-1:0]  group_id;
    logic             opened_new;
    logic             overflow;
    logic [GIU_W-1:0] groups_in_use;
  } alloc_result_t;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic              typed;
    alloc_result_t     want;
  } dir_row_t;

  // Rows with typed == 1 carry their own expected result.
  localparam dir_row_t DIRECTED [N_DIR] = '{
    {20'd0,  1'b1, 10'd0, 1'b1, 1'b0, 11'd1},
    {20'd0,  1'b1, 10'd1, 1'b1, 1'b0, 11'd2},
    {20'd1,  1'b1, 10'd2, 1'b1, 1'b0, 11'd3},
    {20'd2,  1'b0, 23'd0},
    {20'd3,  1'b0, 23'd0},
    {20'd3,  1'b0, 23'd0},
    {20'd3,  1'b0, 23'd0},
    {20'd1,  1'b0, 23'd0},
    {20'd10, 1'b0, 23'd0},
    {20'd10, 1'b0, 23'd0},
    {20'd10, 1'b0, 23'd0},
    {20'd10, 1'b0, 23'd0},
    {20'd10, 1'b0, 23'd0},
    {20'd10, 1'b0, 23'd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  cga_req_if req_ch ();
  cga_rsp_if rsp_ch ();

  cooldown_group_allocator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch.sink),
    .out_rsp (rsp_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [TIME_W-1:0] last_use [MAX_GROUPS];
  int                open_groups = 0;
  alloc_result_t     pending_results [$];
  int                mismatches = 0;
  bit                quiet_send = 1'b0;
  bit                quiet_recv = 1'b0;
  int                recv_hold = 0;

  function automatic alloc_result_t assign_group(input logic [TIME_W-1:0] t);
    alloc_result_t     r;
    int                lru;
    logic [TIME_W-1:0] lru_stamp;
    r = '0;
    lru = 0;
    lru_stamp = '0;
    for (int k = 0; k < open_groups; k++) begin
      if (k == 0 || last_use[k] < lru_stamp) begin
        lru = k;
        lru_stamp = last_use[k];
      end
    end
    if (open_groups == 0 || int'(lru_stamp) + 1 >= int'(t)) begin
      if (open_groups >= MAX_GROUPS) begin
        r.overflow = 1'b1;
      end else begin
        r.group_id = ID_W'(open_groups);
        last_use[open_groups] = t;
        open_groups++;
        r.opened_new = 1'b1;
      end
    end else begin
      r.group_id = ID_W'(lru);
      last_use[lru] = t;
    end
    r.groups_in_use = GIU_W'(open_groups);
    return r;
  endfunction

  // Mostly bursts at one time and small steps; rare long jumps and steps back.
  function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] cur);
    int r;
    int nt;
    r = $urandom_range(0, 99);
    nt = int'(cur);
    if (r < 55) nt = nt;
    else if (r < 75) nt = nt + 1;
    else if (r < 90) nt = nt + $urandom_range(2, 4);
    else if (r < 97) nt = nt + $urandom_range(5, 300);
    else if (r < 99) nt = nt + $urandom_range(0, 16'h3fff);
    else nt = $urandom_range(0, nt);
    if (nt > TMAX) nt = TMAX;
    return TIME_W'(nt);
  endfunction

  task automatic send_request(input logic [TIME_W-1:0] t, input logic typed,
                              input alloc_result_t want, output alloc_result_t pred);
    int gap;
    if ($urandom_range(0, 49) == 0) quiet_send = !quiet_send;
    gap = quiet_send ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.request_time <= t;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pred = assign_group(t);
    pending_results = {pending_results, (typed ? want : pred)};
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n || recv_hold > 0) begin
      rsp_ch.ready <= 1'b0;
      if (recv_hold > 0) recv_hold--;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.group_id, rsp_ch.opened_new, rsp_ch.overflow, rsp_ch.groups_in_use};
      if (pending_results.size() == 0) begin
        if (mismatches < SHOW_MAX)
          $display("%0t: unexpected transaction gid=%0d new=%0d ovf=%0d giu=%0d", $time,
                   got.group_id, got.opened_new, got.overflow, got.groups_in_use);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatches < SHOW_MAX) begin
            $write("%0t: expected gid=%0d new=%0d ovf=%0d giu=%0d,", $time,
                   want.group_id, want.opened_new, want.overflow, want.groups_in_use);
            $display(" actual gid=%0d new=%0d ovf=%0d giu=%0d",
                     got.group_id, got.opened_new, got.overflow, got.groups_in_use);
          end
          mismatches++;
        end
      end
      if ($urandom_range(0, 49) == 0) quiet_recv = !quiet_recv;
      recv_hold = quiet_recv ? 0 : $urandom_range(0, 8);
    end
  end

  initial begin
    logic [TIME_W-1:0] now_t;
    alloc_result_t     pred;
    int                overflows;
    rst_n               = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.request_time = '0;
    rsp_ch.ready        = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++)
      send_request(DIRECTED[i].t, DIRECTED[i].typed, DIRECTED[i].want, pred);
    now_t = DIRECTED[N_DIR-1].t;

    for (int i = 0; i < N_MIXED; i++) begin
      if (i == N_MIXED / 2) drain_results();
      now_t = next_time(now_t);
      send_request(now_t, 1'b0, '0, pred);
    end

    // one burst at a single time fills every group, then overflows
    overflows = 0;
    while (overflows < 3) begin
      send_request(now_t, 1'b0, '0, pred);
      if (pred.overflow) overflows++;
    end

    for (int i = 0; i < N_TAIL; i++) begin
      now_t = next_time(now_t);
      send_request(now_t, 1'b0, '0, pred);
    end
    for (int i = 0; i < 4; i++) send_request(TIME_W'(TMAX), 1'b0, '0, pred);
    send_request('0, 1'b0, '0, pred);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
design/cga_pkg.sv
design/cga_ifs.sv
design/cga_heap_ram.sv
design/cooldown_group_allocator.sv
tb/sv/tb_cooldown_group_allocator.sv
